// ===== hw/rtl/sequential_label_relabeler_unit_assert.svh =====
// Assertion macros shared by the relabeler RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef SEQUENTIAL_LABEL_RELABELER_UNIT_ASSERT_SVH
`define SEQUENTIAL_LABEL_RELABELER_UNIT_ASSERT_SVH

// same-cycle implication
`define SLRU_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slru assertion failed");

// next-cycle implication
`define SLRU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slru assertion failed");

`endif

// ===== hw/rtl/slru_pkg.sv =====
// Shared types and constants for the sequential label relabeler.
// No dependencies.
`timescale 1ns / 1ps

package slru_pkg;

	localparam int LABEL_W = 16;

	// controller -> datapath commands
	typedef struct packed {
		logic ld;     // latch item, read forward map, apply start clear
		logic rev_rd; // read reverse map at forward map's number
		logic eval;   // decide result, insert on miss
	} cmd_t;

endpackage

// ===== hw/rtl/slru_ctrl.sv =====
// Controller FSM for the relabeler: sequences load, reverse read and evaluate.
// Depends on slru_pkg and sequential_label_relabeler_unit_assert.svh.
`timescale 1ns / 1ps
`include "sequential_label_relabeler_unit_assert.svh"

module slru_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output slru_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_comb begin
		cmd        = '0;
		cmd.ld     = accept;
		cmd.rev_rd = (state_q == ST_MAP);
		cmd.eval   = (state_q == ST_EVAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAP;
						busy_q  <= 1'b1;
					end
				end
				ST_MAP: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	`SLRU_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`SLRU_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`SLRU_ASSERT_NEXT(a_eval_done, clk, arst_n, cmd.eval, done)
	`SLRU_ASSERT_NOW(a_busy_state, clk, arst_n, busy, cmd.rev_rd || cmd.eval || !busy_q)

endmodule

// ===== hw/rtl/slru_dpath.sv =====
// Datapath for the relabeler: forward map, reverse map, counter, result register.
// Depends on slru_pkg.
`timescale 1ns / 1ps

module slru_dpath #(
	parameter int LABELS = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slru_pkg::cmd_t               cmd,
	input  logic                         opcode,
	input  logic [slru_pkg::LABEL_W-1:0] label,
	input  logic                         start_req,
	output logic [slru_pkg::LABEL_W-1:0] new_label
);

	localparam int MAP_DEPTH = (LABELS < (1 << slru_pkg::LABEL_W)) ?
		LABELS : (1 << slru_pkg::LABEL_W);
	localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam logic [slru_pkg::LABEL_W:0] LIMIT = (slru_pkg::LABEL_W + 1)'(MAP_DEPTH);

	// forward map label -> number, reverse map number -> label; a forward entry
	// counts only if its number was handed out since the last clear and the
	// reverse entry points back at it, so neither store needs clearing
	bit [AW-1:0] map_mem [MAP_DEPTH];
	bit [AW-1:0] rev_mem [MAP_DEPTH];

	logic                         op_q;
	logic [slru_pkg::LABEL_W-1:0] label_q;
	logic [AW-1:0]                next_q;
	logic [AW-1:0]                map_rd_q;
	logic [AW-1:0]                rev_rd_q;
	logic [slru_pkg::LABEL_W-1:0] result_q;

	logic          nz;
	logic          in_range;
	logic          hit;
	logic          ins;
	logic [AW-1:0] inc;
	logic [slru_pkg::LABEL_W-1:0] result_d;

	always_comb begin
		nz       = (label_q != '0);
		in_range = ({1'b0, label_q} < LIMIT);
		hit      = (map_rd_q != '0) && (map_rd_q <= next_q) &&
			(rev_rd_q == label_q[AW-1:0]);
		inc      = next_q + AW'(1);
		ins      = nz && in_range && !hit && !op_q;
		if (!(nz && in_range)) begin
			result_d = '0;
		end else if (hit) begin
			result_d = slru_pkg::LABEL_W'(map_rd_q);
		end else if (ins) begin
			result_d = slru_pkg::LABEL_W'(inc);
		end else begin
			result_d = '0;
		end
	end

	// counter: control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
		end else begin
			if (cmd.ld && start_req) begin
				next_q <= '0;
			end else if (cmd.eval && ins) begin
				next_q <= inc;
			end
		end
	end

	// payload and memories
	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			op_q     <= opcode;
			label_q  <= label;
			map_rd_q <= map_mem[label[AW-1:0]];
		end
		if (cmd.rev_rd) begin
			rev_rd_q <= rev_mem[map_rd_q];
		end
		if (cmd.eval) begin
			result_q <= result_d;
			if (ins) begin
				map_mem[label_q[AW-1:0]] <= inc;
				rev_mem[inc]             <= label_q[AW-1:0];
			end
		end
	end

	assign new_label = result_q;

endmodule

// ===== hw/rtl/sequential_label_relabeler_unit.sv =====
// Top level of the sequential label relabeler: controller plus datapath.
// Depends on slru_pkg, slru_ctrl, slru_dpath.
`timescale 1ns / 1ps
//
// Channel   Handshake          Payload                       Dir
// --------  -----------------  ----------------------------  ---
// item      start / busy       opcode, label, start_req      in
// result    done (1-cycle)     new_label                     out
//
// An item beat is taken on a clock edge with start high and busy low.
// Each item passes through load + forward map read, reverse map read and
// evaluate + insert before the done strobe; done rises with busy low,
// so a new item may be accepted in the cycle that done is shown.
// The two map memories are single read, single write per cycle; the
// forward read, the reverse read and the write fall in separate FSM states.
// Reset clears the FSM and the counter only; no clearing pass is needed.
// The receiver cannot stall: new_label is valid only while done is high.

module sequential_label_relabeler_unit #(
	parameter int LABELS = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [slru_pkg::LABEL_W-1:0] label,
	input  logic                         start_req,
	output logic                         done,
	output logic [slru_pkg::LABEL_W-1:0] new_label
);

	// command bundle from controller to datapath
	slru_pkg::cmd_t cmd;

	slru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// datapath: label map lookup with verify-by-reverse-map, dense counter
	slru_dpath #(
		.LABELS (LABELS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.opcode    (opcode),
		.label     (label),
		.start_req (start_req),
		.new_label (new_label)
	);

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for sequential_label_relabeler_unit: dense relabeling
// by first appearance, lookups, and start-of-volume clears. Depends on slru_pkg.
`timescale 1ns / 1ps

module tb;

	localparam int LW          = slru_pkg::LABEL_W;
	localparam int MAP_LABELS  = 65536;
	localparam int IDLE_LIMIT  = 2000;  // cycles with no beat while work is outstanding
	localparam int DRAIN_WAIT  = 8;     // extra wait after the drain, before the final check
	localparam int PRINT_LIMIT = 40;

	localparam bit OP_RELABEL = 1'b0;
	localparam bit OP_LOOKUP  = 1'b1;

	typedef struct {
		bit          op;
		bit [LW-1:0] lbl;
		bit          clr;
	} voxel_item_t;

	typedef struct {
		bit          op;
		bit [LW-1:0] lbl;
		bit [LW-1:0] num;
	} dense_expect_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          start     = 1'b0;
	logic          opcode    = 1'b0;
	logic [LW-1:0] label     = '0;
	logic          start_req = 1'b0;
	logic          busy;
	logic          done;
	logic [LW-1:0] new_label;

	voxel_item_t   voxel_queue[$];
	dense_expect_t dense_expected[$];

	// predictor state: original label -> dense number, and last number issued
	bit [LW-1:0] dense_map[bit [LW-1:0]];
	bit [LW-1:0] last_number = '0;

	int gap_pct     = 8;
	int outstanding = 0;
	int stall_count = 0;
	int mismatches  = 0;
	int queued      = 0;

	sequential_label_relabeler_unit #(
		.LABELS(MAP_LABELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.label    (label),
		.start_req(start_req),
		.done     (done),
		.new_label(new_label)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Dense number for one beat; updates the predictor's map and counter.
	function automatic bit [LW-1:0] dense_number(bit op, bit [LW-1:0] lbl, bit clr);
		bit [LW-1:0] num;
		num = '0;
		if (clr) begin
			dense_map.delete();
			last_number = '0;
		end
		// background and out-of-range labels never map
		if (lbl != '0 && lbl < MAP_LABELS) begin
			if (dense_map.exists(lbl)) begin
				num = dense_map[lbl];
			end else if (op == OP_RELABEL) begin
				last_number    = last_number + 1'b1;
				dense_map[lbl] = last_number;
				num            = last_number;
			end
		end
		return num;
	endfunction

	task automatic report_mismatch(string what, dense_expect_t want, bit [LW-1:0] got);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] MISMATCH %s: op %0d label 0x%04h got %0d expected %0d",
				$time, what, want.op, want.lbl, got, want.num);
	endtask

	task automatic queue_item(bit op, bit [LW-1:0] lbl, bit clr);
		voxel_item_t it;
		it.op  = op;
		it.lbl = lbl;
		it.clr = clr;
		voxel_queue.push_back(it);
		outstanding++;
		queued++;
	endtask

	function automatic bit [LW-1:0] pick_label();
		// half small labels so volumes share labels; half full range for bit coverage
		if ($urandom_range(1) == 0)
			return LW'($urandom_range(1, 20));
		return LW'($urandom_range(1, 65535));
	endfunction

	// One segmentation volume: clear, voxel stream over a small label set,
	// then lookups of background, pool and random labels.
	task automatic queue_volume();
		bit [LW-1:0] pool[$];
		int          npool;
		int          nvox;
		npool = $urandom_range(1, 12);
		nvox  = $urandom_range(6, 40);
		repeat (npool) pool.push_back(pick_label());
		queue_item(OP_RELABEL, pool[0], 1'b1);
		repeat (nvox) begin
			if ($urandom_range(9) == 0)
				queue_item(OP_RELABEL, '0, 1'b0);
			else
				queue_item(OP_RELABEL, pool[$urandom_range(pool.size() - 1)], 1'b0);
		end
		repeat ($urandom_range(2, 8)) begin
			case ($urandom_range(5))
				0:       queue_item(OP_LOOKUP, '0, 1'b0);
				1, 2:    queue_item(OP_LOOKUP, pick_label(), 1'b0);
				default: queue_item(OP_LOOKUP, pool[$urandom_range(pool.size() - 1)], 1'b0);
			endcase
		end
	endtask

	// Random traffic until the phase holds about n more beats: mostly whole
	// volumes, some loose beats with random opcode, label and clear.
	task automatic queue_traffic(int n);
		int stop_at;
		stop_at = queued + n;
		while (queued < stop_at) begin
			if ($urandom_range(4) != 0)
				queue_volume();
			else
				repeat ($urandom_range(1, 6))
					queue_item(1'($urandom_range(1)), LW'($urandom_range(65535)),
						$urandom_range(19) == 0);
		end
	endtask

	task automatic wait_drained();
		while (outstanding > 0) @(posedge clk);
	endtask

	// Driver: a beat is taken on an edge with start high and busy low; the
	// expectation is formed from the fields held on that edge.
	always @(posedge clk) begin
		voxel_item_t nxt;
		dense_expect_t exp_num;
		if (arst_n && start && !busy) begin
			exp_num.op  = opcode;
			exp_num.lbl = label;
			exp_num.num = dense_number(opcode, label, start_req);
			dense_expected.push_back(exp_num);
		end
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (voxel_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
				nxt = voxel_queue.pop_front();
				start     <= 1'b1;
				opcode    <= nxt.op;
				label     <= nxt.lbl;
				start_req <= nxt.clr;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: each done strobe is one result beat, checked against the
	// oldest expectation. Also keeps the no-progress count for the watchdog.
	always @(posedge clk) begin
		dense_expect_t want;
		if (arst_n && done) begin
			if (dense_expected.size() == 0) begin
				want.op  = 1'b0;
				want.lbl = '0;
				want.num = '0;
				report_mismatch("unexpected result", want, new_label);
			end else begin
				want = dense_expected.pop_front();
				if (new_label !== want.num)
					report_mismatch("new_label", want, new_label);
			end
			outstanding--;
		end
		if (outstanding <= 0 || (start && !busy) || done)
			stall_count = 0;
		else
			stall_count++;
	end

	initial begin
		while (stall_count < IDLE_LIMIT) @(posedge clk);
		$display("[%0t] timeout: no progress for %0d cycles", $time, IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: background, first appearance, repeats, lookups, clears
		queue_item(OP_RELABEL, '0,       1'b1);  // clear on background beat
		queue_item(OP_LOOKUP,  '0,       1'b0);
		queue_item(OP_LOOKUP,  16'h0001, 1'b0);  // unmapped lookup
		queue_item(OP_RELABEL, 16'h0001, 1'b0);
		queue_item(OP_RELABEL, 16'hFFFF, 1'b0);
		queue_item(OP_RELABEL, 16'h0001, 1'b0);  // seen before
		queue_item(OP_LOOKUP,  16'hFFFF, 1'b0);
		queue_item(OP_LOOKUP,  16'h8000, 1'b0);
		queue_item(OP_RELABEL, 16'h8000, 1'b0);
		queue_item(OP_RELABEL, '0,       1'b0);
		queue_item(OP_LOOKUP,  16'h0001, 1'b1);  // clear then lookup misses
		queue_item(OP_RELABEL, 16'hFFFF, 1'b0);
		queue_item(OP_RELABEL, 16'h5555, 1'b0);
		queue_item(OP_RELABEL, 16'hAAAA, 1'b0);
		queue_item(OP_RELABEL, 16'h5555, 1'b1);  // clear, then first again
		queue_item(OP_LOOKUP,  16'hAAAA, 1'b0);
		queue_item(OP_RELABEL, 16'hAAAA, 1'b0);
		queue_item(OP_LOOKUP,  16'h5555, 1'b0);
		queue_item(OP_RELABEL, '0,       1'b1);
		queue_item(OP_LOOKUP,  16'h5555, 1'b0);
		queue_item(OP_RELABEL, 16'h0002, 1'b0);
		queue_item(OP_RELABEL, 16'h0002, 1'b0);  // back-to-back repeat
		queue_item(OP_LOOKUP,  16'h0002, 1'b0);

		gap_pct = 8;
		queue_traffic(450);
		wait_drained();

		gap_pct = 85;
		queue_traffic(250);
		wait_drained();

		gap_pct = 0;
		queue_traffic(580);
		wait_drained();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (dense_expected.size() != 0)
			report_mismatch("missing result", dense_expected[0], '0);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/slru_pkg.sv
hw/rtl/slru_ctrl.sv
hw/rtl/slru_dpath.sv
hw/rtl/sequential_label_relabeler_unit.sv
tb/tb.sv
